// File: rtl/erm_pkg.sv
// Shared types, constants and register indexes for the echo range meter.
// No dependencies; every other file in rtl/ imports this package.
package erm_pkg;

  localparam int CAP_W      = 16;
  localparam int DIST_W     = 16;
  localparam int AGREE_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OVF_BITS_DEF   = 8;
  localparam int TIMER_BITS_DEF = 16;

  localparam logic [AGREE_W-1:0] AGREE_MAX = 3'd7;
  localparam logic [AGREE_W-1:0] FAST_MIN  = 3'd2;
  localparam logic [DIST_W-1:0]  DIST_MAX  = 16'hFFFF;

  localparam logic [15:0] SCALE_RST   = 16'd712;
  localparam logic [15:0] NEAR_RST    = 16'd700;
  localparam logic [15:0] AGREE_RST   = 16'd8;
  localparam logic [15:0] REJECT_RST  = 16'd30;
  localparam logic [2:0]  CONFIRM_RST = 3'd4;
  localparam logic [7:0]  OFFSET_RST  = 8'd5;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AGREE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REJECT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 3'd5;

  typedef enum logic [1:0] {
    KIND_RISE = 2'd0,
    KIND_FALL = 2'd1,
    KIND_OVF  = 2'd2
  } req_kind_t;

  typedef struct packed {
    logic [15:0] scale_q16;
    logic [15:0] near_limit_mm;
    logic [15:0] agree_tol_mm;
    logic [15:0] reject_tol_mm;
    logic [2:0]  confirm_after;
    logic [7:0]  far_offset_mm;
  } cfg_t;

  typedef struct packed {
    logic              fire;
    logic [DIST_W-1:0] dist_mm;
  } meas_t;

  typedef struct packed {
    logic              fast_scan;
    logic              confirmed_far;
    logic [DIST_W-1:0] distance_mm;
  } res_t;

endpackage

// File: rtl/erm_meter.sv
// Input stage register, edge/overflow timing state and tick-to-millimetre scaling.
// Depends on erm_pkg.
module erm_meter #(
  parameter int OVF_BITS   = 8,
  parameter int TIMER_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [erm_pkg::CAP_W-1:0]   in_cap,
  input  logic                        out_space,
  input  logic [15:0]                 scale_q16,
  output erm_pkg::meas_t              meas
);
  import erm_pkg::*;

  localparam int CapW  = (TIMER_BITS < CAP_W) ? TIMER_BITS : CAP_W;
  localparam int SpanW = OVF_BITS + TIMER_BITS;
  localparam int ExtW  = (SpanW > 32) ? SpanW : 33;

  logic                stage_valid;
  logic [1:0]          stage_kind;
  logic [CAP_W-1:0]    stage_cap;
  logic [CapW-1:0]     start_capture;
  logic [OVF_BITS-1:0] overflow_count;

  logic             advance;
  logic             consume;
  logic [CapW-1:0]  cap;
  logic [SpanW-1:0] span;
  logic [SpanW-1:0] ticks;
  logic [ExtW-1:0]  ticks_ext;
  logic             big;
  logic [47:0]      prod;

  assign advance  = (stage_kind != KIND_FALL) || out_space;
  assign in_ready = !stage_valid || advance;
  assign consume  = stage_valid && advance;
  assign cap      = stage_cap[CapW-1:0];

  always_comb begin
    span      = (SpanW'(overflow_count) << TIMER_BITS) + SpanW'(cap);
    ticks     = (span >= SpanW'(start_capture)) ? span - SpanW'(start_capture) : '0;
    ticks_ext = ExtW'(ticks);
    big       = (|ticks_ext[ExtW-1:32]) && (scale_q16 != '0);
    prod      = 48'(ticks_ext[31:0]) * 48'(scale_q16);
    meas.fire = consume && (stage_kind == KIND_FALL);
    meas.dist_mm = (big || (|prod[47:32])) ? DIST_MAX : prod[31:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_kind <= in_kind;
      stage_cap  <= in_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_capture  <= '0;
      overflow_count <= '0;
    end else if (consume) begin
      case (stage_kind)
        KIND_RISE: begin
          start_capture  <= cap;
          overflow_count <= '0;
        end
        KIND_FALL: overflow_count <= '0;
        KIND_OVF: begin
          if (overflow_count != {OVF_BITS{1'b1}}) begin
            overflow_count <= overflow_count + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_rise_clears_ovf: assert property (@(posedge clk) disable iff (rst)
    consume && (stage_kind == KIND_RISE) |=> overflow_count == '0)
    else $error("overflow count not cleared by rising edge");

  a_fall_needs_space: assert property (@(posedge clk) disable iff (rst)
    meas.fire |-> out_space)
    else $error("falling edge consumed without result space");

endmodule

// File: rtl/erm_filter.sv
// Near/far decision and agreement filter; builds the result transaction.
// Depends on erm_pkg.
module erm_filter (
  input  logic           clk,
  input  logic           rst,
  input  erm_pkg::cfg_t  cfg,
  input  erm_pkg::meas_t meas,
  output logic           push,
  output erm_pkg::res_t  res
);
  import erm_pkg::*;

  logic [DIST_W-1:0]  reference_mm;
  logic [AGREE_W-1:0] agree_count;
  logic [DIST_W-1:0]  reference_mm_next;
  logic [AGREE_W-1:0] agree_count_next;

  logic              far;
  logic [DIST_W-1:0] ref_eff;
  logic [DIST_W-1:0] diff;
  logic [DIST_W:0]   sum;

  always_comb begin
    far     = meas.dist_mm >= cfg.near_limit_mm;
    ref_eff = (agree_count == '0) ? meas.dist_mm : reference_mm;
    diff    = (ref_eff > meas.dist_mm) ? ref_eff - meas.dist_mm : meas.dist_mm - ref_eff;
    reference_mm_next = ref_eff;
    agree_count_next  = agree_count;
    if (diff < cfg.agree_tol_mm) begin
      reference_mm_next = meas.dist_mm;
      if (agree_count != AGREE_MAX) begin
        agree_count_next = agree_count + 1'b1;
      end
    end else if (diff > cfg.reject_tol_mm) begin
      agree_count_next = '0;
    end
    sum = {1'b0, meas.dist_mm} + (DIST_W + 1)'(cfg.far_offset_mm);
    if (far) begin
      push              = meas.fire && (agree_count_next > cfg.confirm_after);
      res.distance_mm   = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
      res.confirmed_far = 1'b1;
      res.fast_scan     = agree_count_next >= FAST_MIN;
    end else begin
      push              = meas.fire;
      res.distance_mm   = meas.dist_mm;
      res.confirmed_far = 1'b0;
      res.fast_scan     = agree_count >= FAST_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_mm <= '0;
      agree_count  <= '0;
    end else if (meas.fire && far) begin
      reference_mm <= reference_mm_next;
      agree_count  <= agree_count_next;
    end
  end

  a_agree_step: assert property (@(posedge clk) disable iff (rst)
    agree_count != $past(agree_count) |->
      agree_count == '0 || agree_count == $past(agree_count) + 3'd1)
    else $error("agreement counter jumped");

endmodule

// File: rtl/erm_outq.sv
// Two-entry result queue decoupling the filter from the master-side stream.
// Depends on erm_pkg.
module erm_outq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  erm_pkg::res_t              push_data,
  output logic                       space,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [erm_pkg::DIST_W-1:0] m_axis_tdata,
  output logic [1:0]                 m_axis_tuser
);
  import erm_pkg::*;

  res_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign space         = count != 2'd2;
  assign m_axis_tvalid = count != 2'd0;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = q[rd_ptr].distance_mm;
  assign m_axis_tuser  = {q[rd_ptr].fast_scan, q[rd_ptr].confirmed_far};

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !pop |-> !push)
    else $error("result pushed into full queue");

endmodule

// File: rtl/echo_range_meter_with_validation_top.sv
// Echo range meter top: configuration registers and the stage/filter/queue chain.
// Depends on erm_pkg, erm_meter, erm_filter, erm_outq.
//
//  channel   | direction | tdata           | tuser
//  s_axis    | in        | capture_value   | req_type
//  m_axis    | out       | distance_mm     | confirmed_far, fast_scan
//  cfg       | in        | cfg_data by cfg_index on cfg_we
//
// One transaction per cycle unless a falling edge waits in the input stage for
// queue space; an accepted falling edge passes through the input stage register
// and the result queue before its result is offered on m_axis. The scaling
// multiply, filter compares and state update all fit in the single stage.
// Reset clears timing state, filter state and config to defaults.
// A stalled master side fills the two-entry queue; the next falling edge then
// waits in the input stage and holds s_axis_tready low until space frees.
module echo_range_meter_with_validation_top #(
  parameter int OVF_BITS   = erm_pkg::OVF_BITS_DEF,
  parameter int TIMER_BITS = erm_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [erm_pkg::CAP_W-1:0]      s_axis_tdata,  // capture_value
  input  logic [1:0]                     s_axis_tuser,  // req_type
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [erm_pkg::DIST_W-1:0]     m_axis_tdata,  // distance_mm
  output logic [1:0]                     m_axis_tuser,  // confirmed_far, fast_scan
  input  logic                           cfg_we,
  input  logic [erm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [erm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import erm_pkg::*;

  cfg_t  cfg;
  meas_t meas;
  res_t  res;
  logic  push;
  logic  space;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_q16     <= SCALE_RST;
      cfg.near_limit_mm <= NEAR_RST;
      cfg.agree_tol_mm  <= AGREE_RST;
      cfg.reject_tol_mm <= REJECT_RST;
      cfg.confirm_after <= CONFIRM_RST;
      cfg.far_offset_mm <= OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE:   cfg.scale_q16     <= cfg_data;
        REG_NEAR:    cfg.near_limit_mm <= cfg_data;
        REG_AGREE:   cfg.agree_tol_mm  <= cfg_data;
        REG_REJECT:  cfg.reject_tol_mm <= cfg_data;
        REG_CONFIRM: cfg.confirm_after <= cfg_data[2:0];
        REG_OFFSET:  cfg.far_offset_mm <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  erm_meter #(
    .OVF_BITS   (OVF_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_meter (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser),
    .in_cap    (s_axis_tdata),
    .out_space (space),
    .scale_q16 (cfg.scale_q16),
    .meas      (meas)
  );

  erm_filter u_filter (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .meas (meas),
    .push (push),
    .res  (res)
  );

  erm_outq u_outq (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .push_data     (res),
    .space         (space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
